/* src/mme_pkg.sv */
// Shared constants, opcodes, register indexes and control structs of the matrix multiply engine.
`default_nettype none

package mme_pkg;

	// Default sizes handed to the top level parameters
	localparam int DEF_MAX_DIM       = 8;
	localparam int DEF_ELEMENT_WIDTH = 16;

	// Fixed field widths of the item and result words
	localparam int OPCODE_W = 2;
	localparam int INDEX_W  = 6;
	localparam int VALUE_W  = 16;
	localparam int SUM_W    = 35;
	localparam int CFG_W    = 4;

	// Configuration port
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;

	// Input opcodes
	localparam logic [OPCODE_W-1:0] OP_WRITE_A = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_WRITE_B = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_COMPUTE = 2'd2;

	// Register indexes (byte address is 4 * index)
	localparam logic [1:0] REG_ROWS  = 2'd0;
	localparam logic [1:0] REG_INNER = 2'd1;
	localparam logic [1:0] REG_COLS  = 2'd2;

	localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

	// Controller to datapath commands
	typedef struct packed {
		logic wr_a;        // write element into A store
		logic wr_b;        // write element into B store
		logic issue;       // read one A/B term pair
		logic first_term;  // term starts a new sum
		logic last_term;   // term closes the sum
		logic last_item;   // closing sum is the last C element
	} mme_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic pipe_busy;   // terms still in the read/multiply stages
		logic out_full;    // output register holds a word
	} mme_status_t;

endpackage

`default_nettype wire

/* src/mme_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module mme_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* src/mme_ctrl.sv */
// Controller: item handshake, loop counters over i, j, k and store address generation.
`default_nettype none

module mme_ctrl #(
	parameter int MAX_DIM = 8
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 item_valid,
	output      logic                                 item_stall,
	input  wire logic [mme_pkg::OPCODE_W-1:0]         opcode,
	input  wire logic [mme_pkg::INDEX_W-1:0]          element_index,
	input  wire logic [mme_pkg::CFG_W-1:0]            rows_cfg,
	input  wire logic [mme_pkg::CFG_W-1:0]            inner_cfg,
	input  wire logic [mme_pkg::CFG_W-1:0]            cols_cfg,
	output      mme_pkg::mme_cmd_t                    cmd,
	output      logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   a_addr,
	output      logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   b_addr,
	input  wire mme_pkg::mme_status_t                 status
);

	import mme_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int DW    = $clog2(MAX_DIM + 1);
	localparam int CW    = $clog2(MAX_DIM);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] i_q, j_q, k_q;
	logic [AW-1:0] a_base_q, a_addr_q, b_addr_q;
	logic          done_q;

	logic [DW-1:0] rows, inner, cols;
	logic          item_accept, idx_ok;
	logic          last_k, last_j, last_i, drained;

	// Register value 0 acts as 1, above MAX_DIM acts as MAX_DIM
	function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
		logic [DW-1:0] r;
		if (v == '0) begin
			r = DW'(1);
		end else if (v > CFG_W'(MAX_DIM)) begin
			r = DW'(MAX_DIM);
		end else begin
			r = v[DW-1:0];
		end
		return r;
	endfunction

	assign rows  = clamp_dim(rows_cfg);
	assign inner = clamp_dim(inner_cfg);
	assign cols  = clamp_dim(cols_cfg);

	// Input handshake and store writes
	assign item_stall  = (state_q != ST_IDLE);
	assign item_accept = item_valid && !item_stall;
	assign idx_ok      = {1'b0, element_index} < (INDEX_W + 1)'(DEPTH);

	// Loop end flags
	assign last_k = (DW'(k_q) == inner - DW'(1));
	assign last_j = (DW'(j_q) == cols - DW'(1));
	assign last_i = (DW'(i_q) == rows - DW'(1));

	// Next element may start once the pipeline and output word are clear;
	// after the last element only the pipeline has to empty
	assign drained = done_q ? !status.pipe_busy : (!status.pipe_busy && !status.out_full);

	always_comb begin
		cmd            = '0;
		cmd.wr_a       = item_accept && (opcode == OP_WRITE_A) && idx_ok;
		cmd.wr_b       = item_accept && (opcode == OP_WRITE_B) && idx_ok;
		cmd.issue      = (state_q == ST_ISSUE);
		cmd.first_term = (k_q == '0);
		cmd.last_term  = last_k;
		cmd.last_item  = last_k && last_j && last_i;
	end

	assign a_addr = a_addr_q;
	assign b_addr = b_addr_q;

	// Sequencer: walk k per cycle, then j, then i
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			a_base_q <= '0;
			a_addr_q <= '0;
			b_addr_q <= '0;
			done_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_accept && (opcode == OP_COMPUTE)) begin
						i_q      <= '0;
						j_q      <= '0;
						k_q      <= '0;
						a_base_q <= '0;
						a_addr_q <= '0;
						b_addr_q <= '0;
						done_q   <= 1'b0;
						state_q  <= ST_WAIT;
					end
				end
				ST_ISSUE: begin
					if (!last_k) begin
						k_q      <= k_q + CW'(1);
						a_addr_q <= a_addr_q + AW'(1);
						b_addr_q <= b_addr_q + AW'(cols);
					end else begin
						k_q     <= '0;
						state_q <= ST_WAIT;
						if (last_i && last_j) begin
							done_q <= 1'b1;
						end
						if (last_j) begin
							j_q      <= '0;
							i_q      <= i_q + CW'(1);
							a_base_q <= a_base_q + AW'(inner);
							a_addr_q <= a_base_q + AW'(inner);
							b_addr_q <= '0;
						end else begin
							j_q      <= j_q + CW'(1);
							a_addr_q <= a_base_q;
							b_addr_q <= AW'(j_q) + AW'(1);
						end
					end
				end
				ST_WAIT: begin
					if (drained) begin
						state_q <= done_q ? ST_IDLE : ST_ISSUE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A sum is only started with an empty output word
	a_issue_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |-> !status.out_full)
		else $error("term issued while output word still full");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_a, cmd.wr_b, cmd.issue}))
		else $error("store write overlaps term issue");

	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |-> (DW'(k_q) < inner))
		else $error("inner counter ran past inner dimension");

endmodule

`default_nettype wire

/* src/mme_dpath.sv */
// Datapath: A and B stores, multiply stage, accumulator and output word register.
`default_nettype none

module mme_dpath #(
	parameter int MAX_DIM       = 8,
	parameter int ELEMENT_WIDTH = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire mme_pkg::mme_cmd_t                    cmd,
	input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   a_addr,
	input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   b_addr,
	input  wire logic [mme_pkg::INDEX_W-1:0]          element_index,
	input  wire logic signed [mme_pkg::VALUE_W-1:0]   element_value,
	output      logic                                 result_valid,
	input  wire logic                                 result_stall,
	output      logic signed [mme_pkg::SUM_W-1:0]     product_sum,
	output      logic                                 last_element,
	output      mme_pkg::mme_status_t                 status
);

	import mme_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int EW    = ELEMENT_WIDTH;
	localparam int PW    = 2 * EW;

	logic [EW-1:0]        wdata;
	logic [AW-1:0]        waddr;
	logic [EW-1:0]        a_rd, b_rd;

	logic                 valid_s1, first_s1, last_s1, last_item_s1;
	logic                 valid_s2, first_s2, last_s2, last_item_s2;
	logic signed [PW-1:0] prod_s2;
	logic [SUM_W-1:0]     prod_ext, sum;
	logic [SUM_W-1:0]     acc_q, out_sum_q;
	logic                 out_valid_q, out_last_q;

	// Store word: low bits of the value, zero-filled above 16 bits
	generate
		if (EW <= VALUE_W) begin : g_wnarrow
			assign wdata = element_value[EW-1:0];
		end else begin : g_wwide
			assign wdata = {{(EW - VALUE_W){1'b0}}, element_value};
		end
	endgenerate

	assign waddr = element_index[AW-1:0];

	mme_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (cmd.wr_a),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.issue),
		.raddr (a_addr),
		.rdata (a_rd)
	);

	mme_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (cmd.wr_b),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.issue),
		.raddr (b_addr),
		.rdata (b_rd)
	);

	// Stage 1 tags ride alongside the registered RAM reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		first_s1     <= cmd.first_term;
		last_s1      <= cmd.last_term;
		last_item_s1 <= cmd.last_item;
	end

	// Stage 2: signed product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2      <= PW'($signed(a_rd)) * PW'($signed(b_rd));
		first_s2     <= first_s1;
		last_s2      <= last_s1;
		last_item_s2 <= last_item_s1;
	end

	// Fit the product to the sum width (sign-extend or wrap)
	generate
		if (PW >= SUM_W) begin : g_pwide
			assign prod_ext = prod_s2[SUM_W-1:0];
		end else begin : g_pnarrow
			assign prod_ext = {{(SUM_W - PW){prod_s2[PW-1]}}, prod_s2};
		end
	endgenerate

	assign sum = first_s2 ? prod_ext : (acc_q + prod_ext);

	// Accumulator
	always_ff @(posedge clk) begin
		if (valid_s2) begin
			acc_q <= sum;
		end
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s2 && last_s2) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && last_s2) begin
			out_sum_q  <= sum;
			out_last_q <= last_item_s2;
		end
	end

	assign result_valid = out_valid_q;
	assign product_sum  = $signed(out_sum_q);
	assign last_element = out_last_q;

	assign status.pipe_busy = valid_s1 || valid_s2;
	assign status.out_full  = out_valid_q;

	// A finished sum never lands on a word not yet taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && last_s2) |-> !out_valid_q)
		else $error("finished sum overwrote pending output word");

	// Terms of one sum arrive in consecutive cycles
	a_terms_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !first_s2) |-> $past(valid_s2))
		else $error("gap inside an accumulation");

	// Nothing follows the last element of a run
	a_last_item_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && last_item_s2) |-> !valid_s1)
		else $error("term in flight behind the last element");

endmodule

`default_nettype wire

/* src/matrix_multiply_engine.sv */
// Top level of the matrix multiply engine: configuration registers, controller and datapath.
`default_nettype none

// Computes C = A * B for A of rows_used x inner_used and B of inner_used x cols_used
// (each 1..MAX_DIM, 0 acts as 1, larger values act as MAX_DIM). Opcode 0 and 1 words
// write one element of A or B at a row-major index; an index of MAX_DIM*MAX_DIM or
// more is dropped, and opcode 3 is dropped. An opcode 2 word emits rows*cols sums in
// row-major order, last_element marking the final one; input is stalled until the
// final sum sits in the output register. For each C element both stores are read
// for one term per cycle; the next element starts reading only once the read,
// multiply and accumulate stages have drained and the output word has been taken.
// Elements are signed Q8.8, sums are exact signed Q19.16.
// Registers (APB, byte address 4*i): rows_used, inner_used, cols_used, reset 8.
// Stores are not cleared at reset; every element used must be written first.

module matrix_multiply_engine #(
	parameter int MAX_DIM       = mme_pkg::DEF_MAX_DIM,
	parameter int ELEMENT_WIDTH = mme_pkg::DEF_ELEMENT_WIDTH
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// configuration port
	input  wire logic                                   psel,
	input  wire logic                                   penable,
	input  wire logic                                   pwrite,
	input  wire logic [mme_pkg::APB_ADDR_W-1:0]         paddr,
	input  wire logic [mme_pkg::APB_DATA_W-1:0]         pwdata,
	output      logic [mme_pkg::APB_DATA_W-1:0]         prdata,
	output      logic                                   pready,
	// item channel
	input  wire logic                                   item_valid,
	output      logic                                   item_stall,
	input  wire logic [mme_pkg::OPCODE_W-1:0]           opcode,
	input  wire logic [mme_pkg::INDEX_W-1:0]            element_index,
	input  wire logic signed [mme_pkg::VALUE_W-1:0]     element_value,
	// result channel
	output      logic                                   result_valid,
	input  wire logic                                   result_stall,
	output      logic signed [mme_pkg::SUM_W-1:0]       product_sum,
	output      logic                                   last_element
);

	import mme_pkg::*;

	localparam int AW = $clog2(MAX_DIM * MAX_DIM);

	logic [CFG_W-1:0] rows_q, inner_q, cols_q;
	logic             cfg_write;
	logic [1:0]       reg_idx;
	mme_cmd_t         cmd;
	mme_status_t      status;
	logic [AW-1:0]    a_addr, b_addr;

	// Register file
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_idx   = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= DIM_RESET;
			inner_q <= DIM_RESET;
			cols_q  <= DIM_RESET;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_ROWS:  rows_q  <= pwdata[CFG_W-1:0];
				REG_INNER: inner_q <= pwdata[CFG_W-1:0];
				REG_COLS:  cols_q  <= pwdata[CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			REG_ROWS:  prdata = APB_DATA_W'(rows_q);
			REG_INNER: prdata = APB_DATA_W'(inner_q);
			REG_COLS:  prdata = APB_DATA_W'(cols_q);
			default:   prdata = '0;
		endcase
	end

	mme_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.opcode        (opcode),
		.element_index (element_index),
		.rows_cfg      (rows_q),
		.inner_cfg     (inner_q),
		.cols_cfg      (cols_q),
		.cmd           (cmd),
		.a_addr        (a_addr),
		.b_addr        (b_addr),
		.status        (status)
	);

	mme_dpath #(.MAX_DIM(MAX_DIM), .ELEMENT_WIDTH(ELEMENT_WIDTH)) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.a_addr        (a_addr),
		.b_addr        (b_addr),
		.element_index (element_index),
		.element_value (element_value),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.product_sum   (product_sum),
		.last_element  (last_element),
		.status        (status)
	);

endmodule

`default_nettype wire
